/* hw/rtl/life_grid_generation_engine_macros.svh */
// assertion macros for the life grid engine
`ifndef LIFE_GRID_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LGE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lge_pkg.sv */
// shared types, codes and the neighbour rule for the life grid engine
`default_nettype none
package lge_pkg;

	localparam int MAX_COLS = 64;
	localparam int DEF_ROWS = 32;
	localparam int DEF_COLS = 64;

	typedef logic [MAX_COLS-1:0] row_t;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_READ    = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEN,
		ST_RD,
		ST_WAIT,
		ST_OUT
	} state_t;

	// next generation of the middle row; bits beyond the grid must be zero
	function automatic row_t life_row(input row_t up, input row_t mid, input row_t dn);
		row_t nxt;
		logic [3:0] live;
		logic l_up, l_mid, l_dn, r_up, r_mid, r_dn;
		nxt = '0;
		for (int c = 0; c < MAX_COLS; c++) begin
			l_up  = (c > 0) ? up[c-1]  : 1'b0;
			l_mid = (c > 0) ? mid[c-1] : 1'b0;
			l_dn  = (c > 0) ? dn[c-1]  : 1'b0;
			r_up  = (c < MAX_COLS-1) ? up[c+1]  : 1'b0;
			r_mid = (c < MAX_COLS-1) ? mid[c+1] : 1'b0;
			r_dn  = (c < MAX_COLS-1) ? dn[c+1]  : 1'b0;
			live = 4'(l_up) + 4'(up[c]) + 4'(r_up) + 4'(l_mid) + 4'(r_mid)
				+ 4'(l_dn) + 4'(dn[c]) + 4'(r_dn);
			nxt[c] = (live == 4'd3) || (mid[c] && live == 4'd2);
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/lge_in_if.sv */
// request channel of the life grid engine
`default_nettype none
interface lge_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [4:0] row;
	logic [5:0] col;
	logic       alive_in;

	modport source (output valid, action, row, col, alive_in, input ready);
	modport sink (input valid, action, row, col, alive_in, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lge_out_if.sv */
// result channel of the life grid engine
`default_nettype none
interface lge_out_if;
	logic valid;
	logic ready;
	logic cell_alive;
	logic done_res;

	modport source (output valid, cell_alive, done_res, input ready);
	modport sink (input valid, cell_alive, done_res, output ready);
endinterface
`default_nettype wire

/* hw/rtl/life_grid_generation_engine.sv */
// bounded b3/s23 life grid with cell write, cell read and generation step
// usage:
// cmd carries one request: write a cell, read a cell or advance one generation.
// rsp returns one result per request: the addressed cell after the action and
// a done flag, which is low only for the unused action code.
// cmd.ready is high only while the engine is idle; one request is worked at a
// time. write and read step through ST_RD, ST_WAIT and ST_OUT, and rsp.valid
// rises once ST_OUT loads the output register; an advance first runs the row
// sweep in ST_GEN, which reads one grid row a cycle through the single read
// port, runs the row-wide neighbour logic on a window of three rows and writes
// the new row back in place two rows behind, then steps through the same states.
// the unused action code goes straight to ST_OUT.
// the result sits in an output register, so a new request is taken while it
// waits; a stalled rsp holds the engine in its final step until taken.
// reset clears all cells at once through per-row valid bits, with no sweep,
// and empties the output register.
`default_nettype none
`include "life_grid_generation_engine_macros.svh"
module life_grid_generation_engine #(
	parameter int ROWS = lge_pkg::DEF_ROWS,
	parameter int COLS = lge_pkg::DEF_COLS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lge_in_if.sink     cmd,
	lge_out_if.source  rsp
);

	localparam int RW  = $clog2(ROWS);
	localparam int CLW = $clog2(COLS);
	localparam int CNW = $clog2(ROWS + 2);

	lge_pkg::state_t state_q, state_d;

	logic [1:0]      act_q;
	logic [4:0]      row_q;
	logic [5:0]      col_q;
	logic            alive_q;
	logic            inside_q;
	logic [CNW-1:0]  cnt_q;
	logic [COLS-1:0] up_q, mid_q;

	logic [COLS-1:0] mem [ROWS];
	logic [ROWS-1:0] vld_q;
	logic [RW-1:0]   rd_addr;
	logic [COLS-1:0] rd_data_s1;
	logic            rd_vld_s1;
	logic [COLS-1:0] rd_word;

	logic            we;
	logic [RW-1:0]   wa;
	logic [COLS-1:0] wd;

	logic [COLS-1:0] dn_row;
	logic [COLS-1:0] gen_row;
	logic            cell_bit;
	logic            act_ok;
	logic            load_out;
	logic            accept;

	logic res_q;
	logic out_vld_q, out_alive_q, out_done_q;

	assign cmd.ready      = (state_q == lge_pkg::ST_IDLE);
	assign accept         = cmd.valid && cmd.ready;
	assign rsp.valid      = out_vld_q;
	assign rsp.cell_alive = out_alive_q;
	assign rsp.done_res   = out_done_q;

	assign rd_word  = rd_vld_s1 ? rd_data_s1 : '0;
	assign cell_bit = rd_word[CLW'(col_q)];
	assign dn_row   = (int'(cnt_q) <= ROWS) ? rd_word : '0;
	assign gen_row  = COLS'(lge_pkg::life_row(lge_pkg::row_t'(up_q),
		lge_pkg::row_t'(mid_q), lge_pkg::row_t'(dn_row)));
	assign act_ok   = (act_q == lge_pkg::ACT_WRITE) || (act_q == lge_pkg::ACT_ADVANCE)
		|| (act_q == lge_pkg::ACT_READ);

	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		wa       = RW'(row_q);
		wd       = rd_word;
		rd_addr  = RW'(row_q);
		load_out = 1'b0;
		unique case (state_q)
			lge_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					priority if (cmd.action == lge_pkg::ACT_ADVANCE) begin
						state_d = lge_pkg::ST_GEN;
					end else if (cmd.action == lge_pkg::ACT_WRITE
						|| cmd.action == lge_pkg::ACT_READ) begin
						state_d = lge_pkg::ST_RD;
					end else begin
						state_d = lge_pkg::ST_OUT;
					end
				end
			end
			lge_pkg::ST_GEN: begin
				rd_addr = (int'(cnt_q) < ROWS) ? RW'(cnt_q) : '0;
				we      = (int'(cnt_q) >= 2);
				wa      = RW'(cnt_q - CNW'(2));
				wd      = gen_row;
				if (int'(cnt_q) == ROWS + 1) begin
					state_d = lge_pkg::ST_RD;
				end
			end
			lge_pkg::ST_RD: begin
				state_d = lge_pkg::ST_WAIT;
			end
			lge_pkg::ST_WAIT: begin
				if (act_q == lge_pkg::ACT_WRITE && inside_q) begin
					we = 1'b1;
					wd[CLW'(col_q)] = alive_q;
				end
				state_d = lge_pkg::ST_OUT;
			end
			lge_pkg::ST_OUT: begin
				if (!out_vld_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = lge_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lge_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lge_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// grid rows and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// per-row valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	// request fields and row window
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= cmd.action;
			row_q    <= cmd.row;
			col_q    <= cmd.col;
			alive_q  <= cmd.alive_in;
			inside_q <= (int'(cmd.row) < ROWS) && (int'(cmd.col) < COLS);
			up_q     <= '0;
			mid_q    <= '0;
			res_q    <= 1'b0;
		end else if (state_q == lge_pkg::ST_GEN && cnt_q != '0) begin
			up_q  <= mid_q;
			mid_q <= dn_row;
		end else if (state_q == lge_pkg::ST_WAIT) begin
			res_q <= inside_q && ((act_q == lge_pkg::ACT_WRITE) ? alive_q : cell_bit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == lge_pkg::ST_GEN) begin
			cnt_q <= cnt_q + CNW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_alive_q <= act_ok && res_q;
			out_done_q  <= act_ok;
		end
	end

	`LGE_ASSERT_NOW(a_wr_in_grid, we, int'(wa) < ROWS, "write beyond grid")
	`LGE_ASSERT_NEXT(a_sweep_end, state_q == lge_pkg::ST_GEN && int'(cnt_q) == ROWS + 1,
		state_q == lge_pkg::ST_RD, "sweep did not finish")
	`LGE_ASSERT_NEXT(a_busy_after_accept, accept, !cmd.ready, "ready after accept")
	`LGE_ASSERT_NEXT(a_drain, out_vld_q && rsp.ready && !load_out, !out_vld_q,
		"result repeated")
	`LGE_ASSERT_NOW(a_undone_dead, out_vld_q && !out_done_q, !out_alive_q,
		"live cell on undone request")

endmodule
`default_nettype wire

/* tb/life_grid_generation_engine_checker.sv */
// life grid checker: predicts every result from the requests and compares it with the engine
`default_nettype none
module life_grid_generation_engine_checker #(
	parameter int ROWS = lge_pkg::DEF_ROWS,
	parameter int COLS = lge_pkg::DEF_COLS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lge_in_if         cmd,
	lge_out_if        rsp,
	output int        fail_count,
	output int        pending,
	output int        n_advances,
	output int        n_reads,
	output int        peak_live
);

	typedef struct packed {
		logic cell_alive;
		logic done_res;
	} life_result_t;

	logic [COLS-1:0] life [ROWS];
	life_result_t    cell_results_q [$];
	life_result_t    want;
	int              n_results;

	function automatic int population();
		int total;
		total = 0;
		for (int r = 0; r < ROWS; r++)
			total += $countones(life[r]);
		return total;
	endfunction

	// every cell is worked out from the previous generation; no wrap at the edges
	function automatic void step_generation();
		logic [COLS-1:0] prev [ROWS];
		int live;
		prev = life;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS
							&& c + dc >= 0 && c + dc < COLS)
							live += int'(prev[r+dr][c+dc]);
				life[r][c] = (live == 3) || (prev[r][c] && live == 2);
			end
		end
	endfunction

	function automatic life_result_t predict_cell(input logic [1:0] act, input logic [4:0] r,
		input logic [5:0] c, input logic alive);
		life_result_t res;
		logic in_grid;
		in_grid = (int'(r) < ROWS) && (int'(c) < COLS);
		res.done_res = 1'b1;
		unique case (act)
			lge_pkg::ACT_WRITE: begin
				if (in_grid)
					life[r][c] = alive;
			end
			lge_pkg::ACT_ADVANCE: begin
				step_generation();
			end
			lge_pkg::ACT_READ: begin
			end
			default: begin
				res.done_res = 1'b0;
			end
		endcase
		res.cell_alive = (res.done_res && in_grid) ? life[r][c] : 1'b0;
		return res;
	endfunction

	task automatic flag_mismatch(input string field, input logic exp_v, input logic got_v);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch on %s, result %0d: expected %0b, got %0b",
				field, n_results, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				life[r] = '0;
			cell_results_q.delete();
			n_results = 0;
			pending = 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				cell_results_q.push_back(predict_cell(cmd.action, cmd.row, cmd.col,
					cmd.alive_in));
				if (cmd.action == lge_pkg::ACT_ADVANCE) begin
					n_advances++;
					if (population() > peak_live)
						peak_live = population();
				end
				if (cmd.action == lge_pkg::ACT_READ)
					n_reads++;
			end
			if (rsp.valid && rsp.ready) begin
				if (cell_results_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d arrived with no request outstanding", n_results);
				end else begin
					want = cell_results_q.pop_front();
					if (want.cell_alive !== rsp.cell_alive)
						flag_mismatch("cell_alive", want.cell_alive, rsp.cell_alive);
					if (want.done_res !== rsp.done_res)
						flag_mismatch("done_res", want.done_res, rsp.done_res);
				end
				n_results++;
			end
			pending = cell_results_q.size();
		end
	end

endmodule
`default_nettype wire

/* tb/life_grid_generation_engine_tb.sv */
// life grid testbench top: clock, reset, request and result traffic, and the verdict
`default_nettype none
module life_grid_generation_engine_tb;

	localparam int GRID_ROWS = lge_pkg::DEF_ROWS;
	localparam int GRID_COLS = lge_pkg::DEF_COLS;
	localparam int ITEMS = 1400;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 60;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   n_sent;
	int   fails;
	int   pending;
	int   n_advances;
	int   n_reads;
	int   peak_live;

	lge_in_if  cmd ();
	lge_out_if rsp ();

	life_grid_generation_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	life_grid_generation_engine_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.fail_count (fails),
		.pending    (pending),
		.n_advances (n_advances),
		.n_reads    (n_reads),
		.peak_live  (peak_live)
	);

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	// mostly short gaps, a few long ones, none while calm
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(input logic [1:0] act, input int r, input int c,
		input logic alive);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid    <= 1'b1;
		cmd.action   <= act;
		cmd.row      <= 5'(r);
		cmd.col      <= 6'(c);
		cmd.alive_in <= alive;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		n_sent++;
	endtask

	// seed a small patch, then let it evolve and look around it
	task automatic life_episode();
		int r0, c0, h, w, k, roll;
		h = $urandom_range(3, 8);
		w = $urandom_range(3, 10);
		roll = $urandom_range(0, 9);
		r0 = (roll == 0) ? 0 : (roll == 1) ? GRID_ROWS - h : $urandom_range(0, GRID_ROWS - h);
		roll = $urandom_range(0, 9);
		c0 = (roll == 0) ? 0 : (roll == 1) ? GRID_COLS - w : $urandom_range(0, GRID_COLS - w);
		k = $urandom_range(3, 14);
		repeat (k)
			send_request(lge_pkg::ACT_WRITE, r0 + $urandom_range(0, h - 1),
				c0 + $urandom_range(0, w - 1), $urandom_range(0, 5) != 0);
		repeat ($urandom_range(1, 6)) begin
			send_request(lge_pkg::ACT_ADVANCE, r0 + $urandom_range(0, h - 1),
				c0 + $urandom_range(0, w - 1), 1'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 2))
				send_request(lge_pkg::ACT_READ, r0 + $urandom_range(0, h - 1),
					c0 + $urandom_range(0, w - 1), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic noise_episode();
		repeat ($urandom_range(1, 4))
			send_request(2'($urandom_range(0, 3)), $urandom_range(0, GRID_ROWS - 1),
				$urandom_range(0, GRID_COLS - 1), 1'($urandom_range(0, 1)));
	endtask

	// result side: random stalls, plus two long hold-offs to back the engine up
	initial begin
		bit held_early, held_late;
		int burst;
		int stall;
		held_early = 1'b0;
		held_late = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge clk);
		wait (arst_n === 1'b1);
		forever begin
			if ((!held_early && n_sent >= 30) || (!held_late && n_sent >= 800)) begin
				if (held_early)
					held_late = 1'b1;
				held_early = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = pick_gap();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			burst = $urandom_range(1, 6);
			repeat (burst) @(posedge clk);
		end
	end

	initial begin
		int waited;
		calm = 1'b0;
		n_sent = 0;
		arst_n       <= 1'b0;
		cmd.valid    <= 1'b0;
		cmd.action   <= lge_pkg::ACT_WRITE;
		cmd.row      <= '0;
		cmd.col      <= '0;
		cmd.alive_in <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(lge_pkg::ACT_READ, 0, 0, 1'b0);
		send_request(lge_pkg::ACT_WRITE, 0, 0, 1'b1);
		send_request(lge_pkg::ACT_READ, 0, 0, 1'b1);
		send_request(lge_pkg::ACT_WRITE, 0, GRID_COLS - 1, 1'b1);
		send_request(lge_pkg::ACT_WRITE, GRID_ROWS - 1, 0, 1'b1);
		send_request(lge_pkg::ACT_WRITE, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);
		send_request(lge_pkg::ACT_READ, GRID_ROWS - 1, GRID_COLS - 1, 1'b0);
		// lone corners die unless the edges wrap
		send_request(lge_pkg::ACT_ADVANCE, 0, 0, 1'b1);
		send_request(lge_pkg::ACT_READ, GRID_ROWS - 1, 0, 1'b0);
		// blinker against the right edge
		send_request(lge_pkg::ACT_WRITE, 1, GRID_COLS - 3, 1'b1);
		send_request(lge_pkg::ACT_WRITE, 1, GRID_COLS - 2, 1'b1);
		send_request(lge_pkg::ACT_WRITE, 1, GRID_COLS - 1, 1'b1);
		send_request(lge_pkg::ACT_ADVANCE, 0, GRID_COLS - 2, 1'b0);
		send_request(lge_pkg::ACT_READ, 1, GRID_COLS - 1, 1'b0);
		send_request(lge_pkg::ACT_ADVANCE, 1, GRID_COLS - 1, 1'b1);
		send_request(lge_pkg::ACT_WRITE, 1, GRID_COLS - 2, 1'b0);
		send_request(ACT_UNUSED, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);
		send_request(ACT_UNUSED, 0, 0, 1'b0);
		send_request(lge_pkg::ACT_READ, 1, GRID_COLS - 2, 1'b1);
		// birth in the bottom left corner
		send_request(lge_pkg::ACT_WRITE, GRID_ROWS - 2, 0, 1'b1);
		send_request(lge_pkg::ACT_WRITE, GRID_ROWS - 2, 1, 1'b1);
		send_request(lge_pkg::ACT_WRITE, GRID_ROWS - 1, 1, 1'b1);
		send_request(lge_pkg::ACT_ADVANCE, GRID_ROWS - 1, 0, 1'b1);
		send_request(lge_pkg::ACT_ADVANCE, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);

		while (n_sent < ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7)
				life_episode();
			else
				noise_episode();
		end
		cmd.valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d generation steps and %0d cell reads among them",
			n_sent, n_advances, n_reads);
		$display("peak population %0d cells, result side held off twice for %0d cycles",
			peak_live, HOLD_CYCLES);
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/lge_pkg.sv
hw/rtl/lge_in_if.sv
hw/rtl/lge_out_if.sv
hw/rtl/life_grid_generation_engine.sv
tb/life_grid_generation_engine_checker.sv
tb/life_grid_generation_engine_tb.sv
